// File: rtl/fmbq_pkg.sv
// Shared widths, request codes and status codes for the front/middle/back queue.
// No dependencies; used by front_middle_back_queue.
package fmbq_pkg;

    localparam int DATA_W    = 32;
    localparam int REQ_W     = 3;
    localparam int STAT_W    = 2;
    localparam int OCC_W     = 7;
    localparam int DEPTH_DEF = 64;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_MID   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_POP_MID    = 3'd4;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

endpackage

// File: rtl/front_middle_back_queue.sv
// Bounded deque of signed 32-bit values with push/pop at front, middle and back.
// Depends on fmbq_pkg for widths and codes.
//
// Usage:
//   Input channel (i_valid/o_ready) carries one request word: i_req_type and
//   i_push_value. Output channel (o_valid/i_ready) returns one result word per
//   request: o_pop_value, o_status, o_occupancy (count after the request).
//   One request is in flight at a time; o_ready is high only when no request
//   is being worked on and no result is waiting.
//   Push front/back and rejected or unused requests present the result in
//   the cycle after acceptance. Pops read the element from the store and
//   capture it. A middle push or pop moves each element behind the middle
//   by one slot: the single-port-write element store moves one element per
//   cycle. After the result is taken the block returns to idle before the
//   next request is accepted.
//   Reset empties the queue and drops any request or result in flight; store
//   contents are not cleared. While the receiver stalls the result holds on
//   the output and no new request is accepted.
module front_middle_back_queue #(
    parameter int DEPTH = fmbq_pkg::DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic        [fmbq_pkg::REQ_W-1:0]  i_req_type,
    input  logic signed [fmbq_pkg::DATA_W-1:0] i_push_value,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [fmbq_pkg::DATA_W-1:0] o_pop_value,
    output logic        [fmbq_pkg::STAT_W-1:0] o_status,
    output logic        [fmbq_pkg::OCC_W-1:0]  o_occupancy
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = fmbq_pkg::DATA_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CAP,
        S_SHIFT,
        S_OUT
    } t_state;

    t_state                     r_state, n_state;
    logic [AW-1:0]              r_head, n_head;
    logic [CW-1:0]              r_count, n_count;
    logic [CW-1:0]              r_idx, n_idx;
    logic [CW-1:0]              r_left, n_left;
    logic                       r_ins, n_ins;
    logic                       r_pend, n_pend;
    logic [AW-1:0]              r_waddr, n_waddr;
    logic [AW-1:0]              r_faddr, n_faddr;
    logic [DW-1:0]              r_val, n_val;
    logic [DW-1:0]              r_pop, n_pop;
    logic [fmbq_pkg::STAT_W-1:0] r_status, n_status;

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [DW-1:0] mem_wd;
    logic          mem_re;
    logic [AW-1:0] mem_ra;

    logic [CW-1:0] k_mid_push;
    logic [CW-1:0] k_mid_pop;

    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] head,
                                             input logic [CW-1:0] idx);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(idx);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = (r_state == S_OUT);
    assign o_pop_value = r_pop;
    assign o_status    = r_status;
    assign o_occupancy = fmbq_pkg::OCC_W'(r_count);

    assign k_mid_push = r_count >> 1;
    assign k_mid_pop  = (r_count - CW'(1)) >> 1;

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_count  = r_count;
        n_idx    = r_idx;
        n_left   = r_left;
        n_ins    = r_ins;
        n_pend   = r_pend;
        n_waddr  = r_waddr;
        n_faddr  = r_faddr;
        n_val    = r_val;
        n_pop    = r_pop;
        n_status = r_status;
        mem_we   = 1'b0;
        mem_wa   = '0;
        mem_wd   = i_push_value;
        mem_re   = 1'b0;
        mem_ra   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_pop    = '0;
                    n_status = fmbq_pkg::ST_OK;
                    n_pend   = 1'b0;
                    n_left   = '0;
                    n_state  = S_OUT;
                    case (i_req_type) inside
                        fmbq_pkg::REQ_PUSH_FRONT, fmbq_pkg::REQ_PUSH_MID,
                        fmbq_pkg::REQ_PUSH_BACK: begin
                            if (r_count >= DEPTH_C) begin
                                n_status = fmbq_pkg::ST_FULL;
                            end else if (i_req_type == fmbq_pkg::REQ_PUSH_FRONT) begin
                                n_head  = (r_head == '0) ? AW'(DEPTH - 1)
                                                         : r_head - AW'(1);
                                mem_we  = 1'b1;
                                mem_wa  = n_head;
                                n_count = r_count + CW'(1);
                            end else if (i_req_type == fmbq_pkg::REQ_PUSH_BACK) begin
                                mem_we  = 1'b1;
                                mem_wa  = f_slot(r_head, r_count);
                                n_count = r_count + CW'(1);
                            end else begin
                                n_ins   = 1'b1;
                                n_left  = r_count - k_mid_push;
                                n_idx   = r_count - CW'(1);
                                n_faddr = f_slot(r_head, k_mid_push);
                                n_val   = i_push_value;
                                n_state = S_SHIFT;
                            end
                        end
                        fmbq_pkg::REQ_POP_FRONT, fmbq_pkg::REQ_POP_MID,
                        fmbq_pkg::REQ_POP_BACK: begin
                            if (r_count == '0) begin
                                n_pop    = '1;
                                n_status = fmbq_pkg::ST_EMPTY;
                            end else begin
                                n_ins   = 1'b0;
                                mem_re  = 1'b1;
                                n_state = S_CAP;
                                if (i_req_type == fmbq_pkg::REQ_POP_FRONT) begin
                                    mem_ra = r_head;
                                    n_head = f_slot(r_head, CW'(1));
                                end else if (i_req_type == fmbq_pkg::REQ_POP_BACK) begin
                                    mem_ra = f_slot(r_head, r_count - CW'(1));
                                end else begin
                                    mem_ra = f_slot(r_head, k_mid_pop);
                                    n_left = r_count - CW'(1) - k_mid_pop;
                                    n_idx  = k_mid_pop + CW'(1);
                                end
                            end
                        end
                        default: begin
                            n_status = fmbq_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_CAP: begin
                n_pop   = r_rd;
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                if (r_pend) begin
                    mem_we = 1'b1;
                    mem_wa = r_waddr;
                    mem_wd = r_rd;
                    n_pend = 1'b0;
                end
                if (r_left != '0) begin
                    mem_re  = 1'b1;
                    mem_ra  = f_slot(r_head, r_idx);
                    n_waddr = f_slot(r_head, r_ins ? r_idx + CW'(1) : r_idx - CW'(1));
                    n_idx   = r_ins ? r_idx - CW'(1) : r_idx + CW'(1);
                    n_left  = r_left - CW'(1);
                    n_pend  = 1'b1;
                end else if (!r_pend) begin
                    if (r_ins) begin
                        mem_we  = 1'b1;
                        mem_wa  = r_faddr;
                        mem_wd  = r_val;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_count = r_count - CW'(1);
                    end
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_left  <= '0;
            r_pend  <= 1'b0;
            r_ins   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_left  <= n_left;
            r_pend  <= n_pend;
            r_ins   <= n_ins;
        end
        r_idx    <= n_idx;
        r_waddr  <= n_waddr;
        r_faddr  <= n_faddr;
        r_val    <= n_val;
        r_pop    <= n_pop;
        r_status <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_ra];
        end
    end

    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("ready and result valid at once");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("element count exceeds depth");

    a_empty_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == fmbq_pkg::ST_EMPTY) |-> (o_pop_value == '1))
        else $error("empty pop without all-ones value");

    a_shift_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && n_state == S_SHIFT) |=> $stable(r_count))
        else $error("count moved during shift");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_pop_value) && $stable(o_status)
                                   && $stable(o_occupancy)))
        else $error("result changed while stalled");

endmodule

// File: test/front_middle_back_queue_tb.sv
// Self-checking testbench for front_middle_back_queue: directed corner cases, fill/drain
// and randomized phases with idle and stall, each result checked against a local deque model.
// Depends on fmbq_pkg and front_middle_back_queue.
module front_middle_back_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QDEPTH = fmbq_pkg::DEPTH_DEF;

    typedef logic [fmbq_pkg::REQ_W-1:0] t_req;
    typedef logic [fmbq_pkg::OCC_W-1:0] t_occ;

    localparam t_req REQ_UNUSED_LO = 3'd6;
    localparam t_req REQ_UNUSED_HI = 3'd7;

    typedef struct {
        logic signed [fmbq_pkg::DATA_W-1:0] pop_value;
        logic        [fmbq_pkg::STAT_W-1:0] status;
        logic        [fmbq_pkg::OCC_W-1:0]  occupancy;
    } t_queue_result;

    logic                               i_clk        = 1'b0;
    logic                               i_rst_n      = 1'b0;
    logic                               i_valid      = 1'b0;
    logic                               o_ready;
    logic        [fmbq_pkg::REQ_W-1:0]  i_req_type   = '0;
    logic signed [fmbq_pkg::DATA_W-1:0] i_push_value = '0;
    logic                               o_valid;
    logic                               i_ready      = 1'b0;
    logic signed [fmbq_pkg::DATA_W-1:0] o_pop_value;
    logic        [fmbq_pkg::STAT_W-1:0] o_status;
    logic        [fmbq_pkg::OCC_W-1:0]  o_occupancy;

    logic signed [fmbq_pkg::DATA_W-1:0] deque_model[$];
    t_queue_result                      pending_results[$];
    int                                 mismatch_count = 0;
    int                                 send_idle_pct  = 0;
    int                                 recv_stall_pct = 0;

    front_middle_back_queue #(
        .DEPTH(QDEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_type  (i_req_type),
        .i_push_value(i_push_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pop_value (o_pop_value),
        .o_status    (o_status),
        .o_occupancy (o_occupancy)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic t_queue_result apply_request(
        input logic [fmbq_pkg::REQ_W-1:0] kind,
        input logic signed [fmbq_pkg::DATA_W-1:0] value);
        t_queue_result res;
        int            idx;
        res.pop_value = '0;
        res.status    = fmbq_pkg::ST_OK;
        case (kind) inside
            fmbq_pkg::REQ_PUSH_FRONT, fmbq_pkg::REQ_PUSH_MID, fmbq_pkg::REQ_PUSH_BACK: begin
                if (deque_model.size() >= QDEPTH) begin
                    res.status = fmbq_pkg::ST_FULL;
                end else if (kind == fmbq_pkg::REQ_PUSH_FRONT) begin
                    deque_model.push_front(value);
                end else if (kind == fmbq_pkg::REQ_PUSH_MID) begin
                    deque_model.insert(deque_model.size() / 2, value);
                end else begin
                    deque_model.push_back(value);
                end
            end
            fmbq_pkg::REQ_POP_FRONT, fmbq_pkg::REQ_POP_MID, fmbq_pkg::REQ_POP_BACK: begin
                if (deque_model.size() == 0) begin
                    res.pop_value = -1;
                    res.status    = fmbq_pkg::ST_EMPTY;
                end else if (kind == fmbq_pkg::REQ_POP_FRONT) begin
                    res.pop_value = deque_model.pop_front();
                end else if (kind == fmbq_pkg::REQ_POP_MID) begin
                    idx           = (deque_model.size() - 1) / 2;
                    res.pop_value = deque_model[idx];
                    deque_model.delete(idx);
                end else begin
                    res.pop_value = deque_model.pop_back();
                end
            end
            default: ;
        endcase
        res.occupancy = t_occ'(deque_model.size());
        return res;
    endfunction

    task automatic note_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
    endtask

    always @(posedge i_clk) begin
        t_queue_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected word, pop_value", 0, longint'(o_pop_value));
            end else begin
                want = pending_results.pop_front();
                if (o_pop_value !== want.pop_value)
                    note_mismatch("pop_value", longint'(want.pop_value),
                                  longint'(o_pop_value));
                if (o_status !== want.status)
                    note_mismatch("status", longint'(want.status), longint'(o_status));
                if (o_occupancy !== want.occupancy)
                    note_mismatch("occupancy", longint'(want.occupancy),
                                  longint'(o_occupancy));
            end
        end
    end

    task automatic send_word(input logic [fmbq_pkg::REQ_W-1:0] kind,
                             input logic signed [fmbq_pkg::DATA_W-1:0] value);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= kind;
        i_push_value <= value;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(apply_request(kind, value));
    endtask

    task automatic wait_results_done();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic logic signed [fmbq_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0000_0000;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_req pick_push();
        return t_req'($urandom_range(fmbq_pkg::REQ_PUSH_BACK, fmbq_pkg::REQ_PUSH_FRONT));
    endfunction

    function automatic t_req pick_pop();
        return t_req'($urandom_range(fmbq_pkg::REQ_POP_BACK, fmbq_pkg::REQ_POP_FRONT));
    endfunction

    function automatic t_req pick_request(input int push_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < 3)
            return t_req'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
        else if ($urandom_range(99) < push_pct)
            return pick_push();
        else
            return pick_pop();
    endfunction

    task automatic test_corner_cases();
        send_word(fmbq_pkg::REQ_POP_FRONT, 0);
        send_word(fmbq_pkg::REQ_POP_MID, 0);
        send_word(fmbq_pkg::REQ_POP_BACK, 0);
        send_word(REQ_UNUSED_LO, 32'sh7fff_ffff);
        send_word(REQ_UNUSED_HI, 32'sh8000_0000);
        send_word(fmbq_pkg::REQ_PUSH_BACK, 32'sh7fff_ffff);
        send_word(fmbq_pkg::REQ_POP_MID, 0);
        send_word(fmbq_pkg::REQ_PUSH_FRONT, 32'sh8000_0000);
        send_word(fmbq_pkg::REQ_PUSH_BACK, -1);
        send_word(fmbq_pkg::REQ_PUSH_MID, 0);
        send_word(fmbq_pkg::REQ_PUSH_MID, 32'sh5555_5555);
        send_word(fmbq_pkg::REQ_PUSH_FRONT, 32'shaaaa_aaaa);
        send_word(REQ_UNUSED_HI, 32'sh1234_5678);
        send_word(fmbq_pkg::REQ_POP_MID, 0);
        send_word(fmbq_pkg::REQ_POP_MID, 0);
        send_word(fmbq_pkg::REQ_POP_FRONT, 0);
        send_word(fmbq_pkg::REQ_POP_BACK, 0);
        send_word(fmbq_pkg::REQ_POP_BACK, 0);
        send_word(fmbq_pkg::REQ_PUSH_FRONT, 1);
        send_word(fmbq_pkg::REQ_POP_FRONT, 0);
        wait_results_done();
    endtask

    task automatic test_fill_and_drain();
        repeat (QDEPTH) send_word(pick_push(), pick_value());
        send_word(fmbq_pkg::REQ_PUSH_FRONT, pick_value());
        send_word(fmbq_pkg::REQ_PUSH_MID, pick_value());
        send_word(fmbq_pkg::REQ_PUSH_BACK, pick_value());
        send_word(REQ_UNUSED_LO, pick_value());
        repeat (QDEPTH) send_word(pick_pop(), pick_value());
        send_word(pick_pop(), pick_value());
        wait_results_done();
    endtask

    task automatic test_random_traffic(input int words, input int idle_pct, input int stall_pct);
        int push_pct;
        int burst;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        burst          = 0;
        push_pct       = 50;
        repeat (words) begin
            if (burst == 0) begin
                burst = $urandom_range(60, 15);
                case ($urandom_range(3))
                    0:       push_pct = 20;
                    1:       push_pct = 50;
                    2:       push_pct = 80;
                    default: push_pct = 95;
                endcase
            end
            burst--;
            send_word(pick_request(push_pct), pick_value());
        end
        wait_results_done();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_corner_cases();
        test_fill_and_drain();
        test_random_traffic(150, 0, 0);
        test_random_traffic(150, 78, 0);
        test_random_traffic(150, 0, 78);
        test_random_traffic(150, 24, 24);
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: front_middle_back_queue.f
rtl/fmbq_pkg.sv
rtl/front_middle_back_queue.sv
test/front_middle_back_queue_tb.sv
